// ===== hw/rtl/stuffed_frame_deframer_macros.svh =====
// Assertion macros shared by the stuffed frame deframer RTL.
`ifndef STUFFED_FRAME_DEFRAMER_MACROS_SVH
`define STUFFED_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SFD_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SFD_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/sfd_pkg.sv =====
// Package with framing constants, status codes and helper functions of the deframer.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  // Framing bytes.
  localparam logic [7:0] BYTE_OPEN      = 8'h7B;
  localparam logic [7:0] BYTE_CLOSE     = 8'h7D;
  localparam logic [7:0] BYTE_ESC       = 8'h60;
  localparam logic [7:0] BYTE_ESC_OPEN  = 8'h5B;
  localparam logic [7:0] BYTE_ESC_CLOSE = 8'h5D;

  // Character classes.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  // Frame layout, in decoded bytes.
  localparam logic [8:0] ADDR_END       = 9'd3;
  localparam logic [8:0] SENDER_END     = 9'd6;
  localparam logic [8:0] MIN_FRAME      = 9'd8;
  localparam logic [8:0] FRAME_CAPACITY = 9'd263;

  // Reset value of the own address register.
  localparam logic [23:0] OWN_ADDRESS_RESET = 24'h53544D;

  // Check value modulus.
  localparam logic [7:0] CRC_MOD = 8'd100;

  typedef logic [3:0] status_t;

  localparam status_t ST_OK        = 4'd0;
  localparam status_t ST_ADDRESS   = 4'd1;
  localparam status_t ST_SENDER    = 4'd2;
  localparam status_t ST_DIGITS    = 4'd3;
  localparam status_t ST_MISMATCH  = 4'd4;
  localparam status_t ST_SHORT     = 4'd5;
  localparam status_t ST_ESCAPE    = 4'd6;
  localparam status_t ST_OVERFLOW  = 4'd7;
  localparam status_t ST_RESTARTED = 4'd8;

  // An 8-bit value is below 3*100, so two compares reduce it modulo 100.
  function automatic logic [6:0] mod100(input logic [7:0] v);
    logic [7:0] r;
    begin
      if (v >= 8'(2 * CRC_MOD)) begin
        r = v - 8'(2 * CRC_MOD);
      end else if (v >= CRC_MOD) begin
        r = v - CRC_MOD;
      end else begin
        r = v;
      end
      return r[6:0];
    end
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
           ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stuffed_frame_deframer.sv =====
// Byte-stuffed frame deframer: unescapes, checks and forwards the payload of each frame.
// Path: an accepted byte waits in the input register until the result register can take a
// beat; it is then processed and any result beat is offered from the result register.
// Throughput: one byte per cycle while the result register is not stalled; the single
// processing step between the input register and the result register sets this rate.
// Reset (rst_n low, synchronous): no frame open, all counters and flags cleared, own
// address back to 0x53544D.
`timescale 1ns / 1ps
`default_nettype none

`include "stuffed_frame_deframer_macros.svh"

module stuffed_frame_deframer
  import sfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [23:0] cfg_own_address,

  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_rx_byte,

  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_end_of_frame,
  output      logic [7:0]  out_data_byte,
  output      status_t     out_status,
  output      logic [23:0] out_sender,
  output      logic [6:0]  out_crc_value
);

  // Configuration register.
  logic [23:0] own_address_r;

  // Input register.
  logic        in_valid_r;
  logic [7:0]  in_byte_r;

  // Frame state.
  logic        in_frame_r,     in_frame_nxt;
  logic        esc_r,          esc_nxt;
  logic [8:0]  cnt_r,          cnt_nxt;
  logic        addr_ok_r,      addr_ok_nxt;
  logic [23:0] sender_r,       sender_nxt;
  logic        sender_ok_r,    sender_ok_nxt;
  logic [7:0]  xor_r,          xor_nxt;
  logic [7:0]  held0_r,        held0_nxt;
  logic [7:0]  held1_r,        held1_nxt;

  // Result register.
  logic        out_valid_r;
  logic        out_eof_r;
  logic [7:0]  out_data_r;
  status_t     out_status_r;
  logic [23:0] out_sender_r;
  logic [6:0]  out_crc_r;

  // Result of the processing step.
  logic        res_emit;
  logic        res_eof;
  logic [7:0]  res_data;
  status_t     res_status;
  logic [23:0] res_sender;
  logic [6:0]  res_crc;

  logic        out_free;
  logic        proc;

  assign cfg_ready = 1'b1;

  // The stored byte is processed whenever the result register can take a beat.
  assign out_free = !out_valid_r || !out_stall;
  assign proc     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  assign out_valid        = out_valid_r;
  assign out_end_of_frame = out_eof_r;
  assign out_data_byte    = out_data_r;
  assign out_status       = out_status_r;
  assign out_sender       = out_sender_r;
  assign out_crc_value    = out_crc_r;

  // One byte of framing, unescaping and checking.
  always_comb begin
    logic       push;
    logic [7:0] dec;
    logic [7:0] own_byte;
    logic [8:0] cnt_inc;
    logic       emit_pay;
    logic [7:0] pay;
    logic [6:0] crc_now;
    logic [6:0] want;
    status_t    code;

    in_frame_nxt  = in_frame_r;
    esc_nxt       = esc_r;
    cnt_nxt       = cnt_r;
    addr_ok_nxt   = addr_ok_r;
    sender_nxt    = sender_r;
    sender_ok_nxt = sender_ok_r;
    xor_nxt       = xor_r;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;

    res_emit   = 1'b0;
    res_eof    = 1'b0;
    res_data   = 8'd0;
    res_status = ST_OK;
    res_sender = 24'd0;
    res_crc    = 7'd0;

    push     = 1'b0;
    dec      = in_byte_r;
    own_byte = 8'd0;
    cnt_inc  = 9'd0;
    emit_pay = 1'b0;
    pay      = 8'd0;
    crc_now  = mod100(xor_r);
    want     = 7'({3'd0, held0_r[3:0]} * 7'd10) + {3'd0, held1_r[3:0]};
    code     = ST_OK;

    // Classify the raw byte.
    if (in_byte_r == BYTE_OPEN) begin
      if (in_frame_r) begin
        res_emit   = 1'b1;
        res_eof    = 1'b1;
        res_status = ST_RESTARTED;
        res_sender = sender_r;
        res_crc    = crc_now;
      end
      in_frame_nxt  = 1'b1;
      esc_nxt       = 1'b0;
      cnt_nxt       = 9'd0;
      addr_ok_nxt   = 1'b1;
      sender_nxt    = 24'd0;
      sender_ok_nxt = 1'b1;
      xor_nxt       = 8'd0;
      held0_nxt     = 8'd0;
      held1_nxt     = 8'd0;
    end else if (!in_frame_r) begin
      // Bytes between frames are dropped.
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      case (in_byte_r)
        BYTE_ESC:       begin push = 1'b1; dec = BYTE_ESC;   end
        BYTE_ESC_OPEN:  begin push = 1'b1; dec = BYTE_OPEN;  end
        BYTE_ESC_CLOSE: begin push = 1'b1; dec = BYTE_CLOSE; end
        default: begin
          in_frame_nxt = 1'b0;
          res_emit     = 1'b1;
          res_eof      = 1'b1;
          res_status   = ST_ESCAPE;
          res_sender   = sender_r;
          res_crc      = crc_now;
        end
      endcase
    end else if (in_byte_r == BYTE_ESC) begin
      esc_nxt = 1'b1;
    end else if (in_byte_r == BYTE_CLOSE) begin
      // Close the frame with the highest-priority failure.
      if (cnt_r < MIN_FRAME) begin
        code = ST_SHORT;
      end else if (!addr_ok_r) begin
        code = ST_ADDRESS;
      end else if (!sender_ok_r) begin
        code = ST_SENDER;
      end else if (!is_digit(held0_r) || !is_digit(held1_r)) begin
        code = ST_DIGITS;
      end else if (want != crc_now) begin
        code = ST_MISMATCH;
      end
      in_frame_nxt = 1'b0;
      res_emit     = 1'b1;
      res_eof      = 1'b1;
      res_status   = code;
      res_sender   = sender_r;
      res_crc      = crc_now;
    end else begin
      push = 1'b1;
    end

    // Route one decoded byte into the header, the check digits or the payload.
    if (push) begin
      case (cnt_r[1:0])
        2'd0:    own_byte = own_address_r[23:16];
        2'd1:    own_byte = own_address_r[15:8];
        default: own_byte = own_address_r[7:0];
      endcase
      if (cnt_r < ADDR_END) begin
        if (own_byte != dec) begin
          addr_ok_nxt = 1'b0;
        end
      end else if (cnt_r < SENDER_END) begin
        sender_nxt = {sender_r[15:0], dec};
        if (!is_letter(dec)) begin
          sender_ok_nxt = 1'b0;
        end
      end else if (cnt_r >= MIN_FRAME) begin
        pay       = held0_r;
        held0_nxt = held1_r;
        held1_nxt = dec;
        emit_pay  = 1'b1;
      end else if (!cnt_r[0]) begin
        held0_nxt = dec;
      end else begin
        held1_nxt = dec;
      end

      cnt_inc = cnt_r + 9'd1;
      if (cnt_inc >= FRAME_CAPACITY) begin
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        res_emit     = 1'b1;
        res_eof      = 1'b1;
        res_status   = ST_OVERFLOW;
        res_sender   = sender_nxt;
        res_crc      = crc_now;
      end else begin
        cnt_nxt = cnt_inc;
        if (emit_pay) begin
          xor_nxt  = xor_r ^ pay;
          res_emit = 1'b1;
          res_data = pay;
        end
      end
    end
  end

  // Configuration, input register, frame state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= OWN_ADDRESS_RESET;
      in_valid_r    <= 1'b0;
      in_frame_r    <= 1'b0;
      esc_r         <= 1'b0;
      cnt_r         <= 9'd0;
      addr_ok_r     <= 1'b0;
      sender_r      <= 24'd0;
      sender_ok_r   <= 1'b0;
      xor_r         <= 8'd0;
      held0_r       <= 8'd0;
      held1_r       <= 8'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        own_address_r <= cfg_own_address;
      end

      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (proc) begin
        in_valid_r <= 1'b0;
      end

      if (proc) begin
        in_frame_r  <= in_frame_nxt;
        esc_r       <= esc_nxt;
        cnt_r       <= cnt_nxt;
        addr_ok_r   <= addr_ok_nxt;
        sender_r    <= sender_nxt;
        sender_ok_r <= sender_ok_nxt;
        xor_r       <= xor_nxt;
        held0_r     <= held0_nxt;
        held1_r     <= held1_nxt;
        out_valid_r <= res_emit;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, loaded without reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
    if (proc && res_emit) begin
      out_eof_r    <= res_eof;
      out_data_r   <= res_data;
      out_status_r <= res_status;
      out_sender_r <= res_sender;
      out_crc_r    <= res_crc;
    end
  end

  // Internal consistency checks.
  `SFD_ASSERT_IMP(a_esc_in_frame, esc_r, in_frame_r, "escape pending outside a frame")
  `SFD_ASSERT_IMP(a_stall_cause, in_stall, out_valid_r && out_stall, "input stalled without a full result")
  `SFD_ASSERT_NXT(a_status_clears, proc && res_emit && res_eof, !in_frame_r || (cnt_r == 9'd0), "frame still open after its status beat")

endmodule

`default_nettype wire

// ===== dv/stuffed_frame_deframer_tb.sv =====
// Self-checking testbench for the stuffed frame deframer: directed frames, then random traffic.
`timescale 1ns / 1ps

module stuffed_frame_deframer_tb;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 30;

  // Bytes that stress escaping, framing and the check digits.
  localparam logic [7:0] TRICKY_BYTES [8] = '{8'h00, 8'hFF, BYTE_ESC, BYTE_OPEN, BYTE_CLOSE,
                                              BYTE_ESC_OPEN, BYTE_ESC_CLOSE, CHAR_ZERO};

  typedef struct packed {
    logic        eof;
    logic [7:0]  data;
    status_t     status;
    logic [23:0] sender;
    logic [6:0]  crc;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_own_address = 24'h0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_end_of_frame;
  logic [7:0]  out_data_byte;
  status_t     out_status;
  logic [23:0] out_sender;
  logic [6:0]  out_crc_value;

  // Deframer state as the testbench predicts it.
  logic [23:0] own_address_reg;
  bit          frame_open;
  bit          escape_seen;
  int          decoded_count;
  bit          address_match;
  logic [23:0] sender_word;
  bit          sender_valid;
  logic [7:0]  payload_xor;
  logic [7:0]  held_pair [2];

  beat_t       awaited_beats [$];
  logic [7:0]  frame_body [$];

  int send_idle_pct = 29;
  int stall_pct = 61;
  int bytes_accepted = 0;
  int mismatches = 0;
  int payload_beats = 0;
  int status_beats = 0;
  int address_writes = 0;
  int cycle_count = 0;
  int status_tally [16];

  stuffed_frame_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_own_address  (cfg_own_address),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_end_of_frame (out_end_of_frame),
    .out_data_byte    (out_data_byte),
    .out_status       (out_status),
    .out_sender       (out_sender),
    .out_crc_value    (out_crc_value)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d result beats still awaited", $time, awaited_beats.size());
      $display("stuffed_frame_deframer regression: fail");
      $finish;
    end
  end

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic bit is_numeral(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Close the predicted frame with one status beat.
  function automatic void finish_frame(input status_t code);
    beat_t s;
    s.eof = 1'b1;
    s.data = 8'h00;
    s.status = code;
    s.sender = sender_word;
    s.crc = 7'(payload_xor % 100);
    frame_open = 1'b0;
    escape_seen = 1'b0;
    awaited_beats.push_back(s);
  endfunction

  // One decoded byte: header checks, then a two-byte delay line for the payload.
  function automatic void take_decoded(input logic [7:0] u);
    int n;
    bit emit;
    logic [7:0] pay;
    beat_t p;
    n = decoded_count;
    emit = 1'b0;
    pay = 8'h00;
    if (n < 3) begin
      if (own_address_reg[8 * (2 - n) +: 8] != u) address_match = 1'b0;
    end else if (n < 6) begin
      sender_word = {sender_word[15:0], u};
      if (!(((u >= CHAR_UPPER_A) && (u <= CHAR_UPPER_Z)) ||
            ((u >= CHAR_LOWER_A) && (u <= CHAR_LOWER_Z)))) sender_valid = 1'b0;
    end else if (n >= 8) begin
      pay = held_pair[0];
      held_pair[0] = held_pair[1];
      held_pair[1] = u;
      emit = 1'b1;
    end else begin
      held_pair[n - 6] = u;
    end
    n++;
    if (n >= FRAME_CAPACITY) begin
      finish_frame(ST_OVERFLOW);
      return;
    end
    decoded_count = n;
    if (emit) begin
      payload_xor ^= pay;
      p = '{eof: 1'b0, data: pay, status: ST_OK, sender: 24'h0, crc: 7'h0};
      awaited_beats.push_back(p);
    end
  endfunction

  // Predict the effect of one accepted raw byte.
  function automatic void deframe_byte(input logic [7:0] b);
    status_t code;
    int wanted;
    if (b == BYTE_OPEN) begin
      if (frame_open) finish_frame(ST_RESTARTED);
      frame_open = 1'b1;
      escape_seen = 1'b0;
      decoded_count = 0;
      address_match = 1'b1;
      sender_word = 24'h0;
      sender_valid = 1'b1;
      payload_xor = 8'h00;
      held_pair[0] = 8'h00;
      held_pair[1] = 8'h00;
    end else if (!frame_open) begin
      // Bytes between frames are dropped.
    end else if (escape_seen) begin
      escape_seen = 1'b0;
      case (b)
        BYTE_ESC:       take_decoded(BYTE_ESC);
        BYTE_ESC_OPEN:  take_decoded(BYTE_OPEN);
        BYTE_ESC_CLOSE: take_decoded(BYTE_CLOSE);
        default:        finish_frame(ST_ESCAPE);
      endcase
    end else if (b == BYTE_ESC) begin
      escape_seen = 1'b1;
    end else if (b == BYTE_CLOSE) begin
      wanted = int'(held_pair[0] - CHAR_ZERO) * 10 + int'(held_pair[1] - CHAR_ZERO);
      if (decoded_count < MIN_FRAME) code = ST_SHORT;
      else if (!address_match) code = ST_ADDRESS;
      else if (!sender_valid) code = ST_SENDER;
      else if (!is_numeral(held_pair[0]) || !is_numeral(held_pair[1])) code = ST_DIGITS;
      else if (wanted != payload_xor % 100) code = ST_MISMATCH;
      else code = ST_OK;
      finish_frame(code);
    end else begin
      take_decoded(b);
    end
  endfunction

  function automatic void compare_field(input string what, input logic [23:0] want,
                                        input logic [23:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endfunction

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk) begin : result_check
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
          $display("%0t: unexpected beat, expected none, actual eof=%0d data=0x%0h status=%0d",
                   $time, out_end_of_frame, out_data_byte, out_status);
      end else begin
        want = awaited_beats.pop_front();
        compare_field("end_of_frame", want.eof, out_end_of_frame);
        compare_field("data_byte", want.data, out_data_byte);
        compare_field("status", want.status, out_status);
        compare_field("sender", want.sender, out_sender);
        compare_field("crc_value", want.crc, out_crc_value);
        if (want.eof) begin
          status_beats++;
          status_tally[want.status]++;
        end else begin
          payload_beats++;
        end
      end
    end
  end

  // Offer one raw byte, with a random gap first, and predict it once accepted.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_rx_byte <= 8'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_accepted++;
    deframe_byte(b);
  endtask

  // Hold the input off until every predicted beat has come and the pipeline is empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_own_address(input logic [23:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_own_address <= value;
    do @(posedge clk); while (!cfg_ready);
    own_address_reg = value;
    address_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Decoded header plus payload: address, three random letters, random payload.
  function automatic void compose_frame(input logic [23:0] addr, input int plen);
    int i;
    int r;
    frame_body.delete();
    frame_body.push_back(addr[23:16]);
    frame_body.push_back(addr[15:8]);
    frame_body.push_back(addr[7:0]);
    for (i = 0; i < 3; i++) begin
      r = $urandom_range(0, 51);
      frame_body.push_back(r < 26 ? 8'(CHAR_UPPER_A + r) : 8'(CHAR_LOWER_A + r - 26));
    end
    for (i = 0; i < plen; i++) begin
      if ($urandom_range(0, 3) == 0) frame_body.push_back(TRICKY_BYTES[$urandom_range(0, 7)]);
      else frame_body.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Two ASCII digits of the payload XOR modulo 100, or a wrong value when asked.
  function automatic void append_check(input bit correct);
    logic [7:0] x;
    int v;
    int i;
    x = 8'h00;
    for (i = 6; i < frame_body.size(); i++) x ^= frame_body[i];
    v = x % 100;
    if (!correct) v = (v + $urandom_range(1, 99)) % 100;
    frame_body.push_back(8'(CHAR_ZERO + v / 10));
    frame_body.push_back(8'(CHAR_ZERO + v % 10));
  endfunction

  // Open a frame, stuff the first upto decoded bytes and optionally close it.
  task automatic send_body(input int upto, input bit add_close);
    int i;
    send_byte(BYTE_OPEN);
    for (i = 0; i < upto; i++) begin
      case (frame_body[i])
        BYTE_ESC: begin
          send_byte(BYTE_ESC);
          send_byte(BYTE_ESC);
        end
        BYTE_OPEN: begin
          send_byte(BYTE_ESC);
          send_byte(BYTE_ESC_OPEN);
        end
        BYTE_CLOSE: begin
          send_byte(BYTE_ESC);
          send_byte(BYTE_ESC_CLOSE);
        end
        default: send_byte(frame_body[i]);
      endcase
    end
    if (add_close) send_byte(BYTE_CLOSE);
  endtask

  // Good frames at the reset address, including escaped payload and check digit extremes.
  task automatic test_good_frames();
    int i;
    compose_frame(own_address_reg, 0);
    append_check(1'b1);
    send_body(frame_body.size(), 1'b1);
    compose_frame(own_address_reg, 0);
    frame_body[3] = CHAR_UPPER_A;
    frame_body[4] = CHAR_LOWER_Z;
    frame_body[5] = CHAR_UPPER_Z;
    for (i = 0; i < 8; i++) frame_body.push_back(TRICKY_BYTES[i]);
    append_check(1'b1);
    send_body(frame_body.size(), 1'b1);
    // Check values 09 and 99 reach both ends of the digit range.
    compose_frame(own_address_reg, 0);
    frame_body[5] = CHAR_LOWER_A;
    frame_body.push_back(8'h09);
    append_check(1'b1);
    send_body(frame_body.size(), 1'b1);
    compose_frame(own_address_reg, 0);
    frame_body.push_back(8'h63);
    append_check(1'b1);
    send_body(frame_body.size(), 1'b1);
  endtask

  // One fault per frame for each close status, plus the priority between them.
  task automatic test_frame_faults();
    logic [7:0] non_letters [4];
    non_letters = '{8'(CHAR_UPPER_A - 1), 8'(CHAR_UPPER_Z + 1),
                    8'(CHAR_LOWER_A - 1), 8'(CHAR_LOWER_Z + 1)};
    compose_frame(own_address_reg, 0);
    append_check(1'b1);
    send_body(7, 1'b1);
    // A short frame with a bad address still reports short.
    compose_frame(~own_address_reg, 0);
    send_body(5, 1'b1);
    compose_frame(own_address_reg ^ 24'h000001, 2);
    append_check(1'b1);
    send_body(frame_body.size(), 1'b1);
    foreach (non_letters[i]) begin
      compose_frame(own_address_reg, 1);
      frame_body[4] = non_letters[i];
      append_check(1'b1);
      send_body(frame_body.size(), 1'b1);
    end
    // Address fault wins over a sender fault.
    compose_frame(own_address_reg ^ 24'h800000, 1);
    frame_body[3] = non_letters[0];
    append_check(1'b1);
    send_body(frame_body.size(), 1'b1);
    compose_frame(own_address_reg, 1);
    append_check(1'b1);
    frame_body[frame_body.size() - 2] = 8'(CHAR_ZERO - 1);
    send_body(frame_body.size(), 1'b1);
    compose_frame(own_address_reg, 2);
    append_check(1'b1);
    frame_body[frame_body.size() - 1] = 8'(CHAR_NINE + 1);
    frame_body[5] = non_letters[3];
    send_body(frame_body.size(), 1'b1);
    compose_frame(own_address_reg, 3);
    append_check(1'b0);
    send_body(frame_body.size(), 1'b1);
  endtask

  // Escape errors, restarts, bytes outside frames and the empty frame.
  task automatic test_escape_and_restart();
    send_byte(BYTE_OPEN);
    send_byte(BYTE_ESC);
    send_byte(CHAR_UPPER_A);
    // Ignored until the next open byte.
    send_byte(CHAR_UPPER_A);
    send_byte(BYTE_CLOSE);
    compose_frame(own_address_reg, 2);
    send_body(8, 1'b0);
    send_byte(BYTE_ESC);
    send_byte(BYTE_CLOSE);
    // An open byte right after an escape still restarts the frame.
    compose_frame(own_address_reg, 3);
    send_body(9, 1'b0);
    send_byte(BYTE_ESC);
    append_check(1'b1);
    send_body(frame_body.size(), 1'b1);
    settle();
    compose_frame(own_address_reg, 1);
    send_body(4, 1'b0);
    append_check(1'b1);
    send_body(frame_body.size(), 1'b1);
    send_byte(BYTE_CLOSE);
    send_byte(8'hFF);
    send_byte(BYTE_ESC);
    send_byte(8'h00);
    send_byte(BYTE_OPEN);
    send_byte(BYTE_CLOSE);
  endtask

  // A frame that runs past the capacity; every byte below the limit still passes.
  task automatic test_frame_capacity();
    compose_frame(own_address_reg, FRAME_CAPACITY - 6);
    append_check(1'b1);
    send_body(frame_body.size(), 1'b1);
    send_byte(CHAR_UPPER_A);
  endtask

  // Address register at its extremes and at a value whose bytes need escaping.
  task automatic test_address_register();
    logic [23:0] settings [3];
    settings = '{24'h000000, 24'hFFFFFF, {BYTE_ESC, BYTE_OPEN, BYTE_CLOSE}};
    foreach (settings[i]) begin
      write_own_address(settings[i]);
      compose_frame(own_address_reg, 3);
      append_check(1'b1);
      send_body(frame_body.size(), 1'b1);
      compose_frame(own_address_reg ^ 24'h010101, 1);
      append_check(1'b1);
      send_body(frame_body.size(), 1'b1);
    end
  endtask

  // Mostly well-formed frames with random content; the rest faults and noise.
  task automatic test_random_traffic(input int send_pct, input int stall_level,
                                     input logic [23:0] addr, input int budget);
    int first;
    int kind;
    int cut;
    int plen;
    write_own_address(addr);
    send_idle_pct = send_pct;
    stall_pct = stall_level;
    first = bytes_accepted;
    while (bytes_accepted - first < budget) begin
      kind = $urandom_range(0, 99);
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
      compose_frame(own_address_reg, plen);
      append_check(!(kind >= 70 && kind < 75));
      cut = $urandom_range(0, frame_body.size() - 1);
      if (kind < 55 || (kind >= 70 && kind < 75)) begin
        send_body(frame_body.size(), 1'b1);
      end else if (kind < 60) begin
        frame_body[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
        send_body(frame_body.size(), 1'b1);
      end else if (kind < 65) begin
        frame_body[$urandom_range(3, 5)] = 8'($urandom_range(0, 255));
        send_body(frame_body.size(), 1'b1);
      end else if (kind < 70) begin
        frame_body[frame_body.size() - 1 - $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
        send_body(frame_body.size(), 1'b1);
      end else if (kind < 80) begin
        send_body($urandom_range(0, 7), 1'b1);
      end else if (kind < 85) begin
        send_body(cut, 1'b0);
        send_byte(BYTE_ESC);
        send_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
        send_byte(BYTE_CLOSE);
      end else if (kind < 90) begin
        // Left open; the next open byte restarts it.
        send_body(cut, 1'b0);
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        send_byte(BYTE_CLOSE);
      end else begin
        send_byte(BYTE_OPEN);
        repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(0, 255)));
        send_byte(BYTE_CLOSE);
      end
      if ($urandom_range(0, 29) == 0) settle();
    end
  endtask

  initial begin : main
    int codes_hit;
    own_address_reg = OWN_ADDRESS_RESET;
    frame_open = 1'b0;
    escape_seen = 1'b0;
    decoded_count = 0;
    address_match = 1'b0;
    sender_word = 24'h0;
    sender_valid = 1'b0;
    payload_xor = 8'h00;
    held_pair[0] = 8'h00;
    held_pair[1] = 8'h00;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_good_frames();
    test_frame_faults();
    test_escape_and_restart();
    test_frame_capacity();
    test_address_register();
    test_random_traffic(29, 61, 24'($urandom), 20);
    test_random_traffic(61, 29, OWN_ADDRESS_RESET, 20);
    test_random_traffic(0, 0, 24'($urandom), 20);

    settle();
    repeat (10) @(posedge clk);
    codes_hit = 0;
    foreach (status_tally[i]) if (status_tally[i] != 0) codes_hit++;
    $display("Run covered %0d input bytes over %0d own-address settings.",
             bytes_accepted, address_writes);
    $display("Checked %0d payload beats and %0d status beats, %0d distinct status codes.",
             payload_beats, status_beats, codes_hit);
    if (mismatches == 0) begin
      $display("stuffed_frame_deframer regression: pass");
    end else begin
      $display("stuffed_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule
